>>> rtl/core/dch_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dch_pkg
// Shared types, codes and scale tables for the diatonic chord harmonizer.
// ---------------------------------------------------------------------------
package dch_pkg;

   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
   localparam logic [3:0] PITCH_CLASSES = 4'd12;
   localparam logic signed [3:0] NO_DEGREE = -4'sd1;

   typedef enum logic [1:0] {
      CSR_ROOT_KEY     = 2'd0,
      CSR_MINOR_MODE   = 2'd1,
      CSR_ZONE_FLOOR   = 2'd2,
      CSR_ZONE_CEILING = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [3:0] root_key;
      logic       minor_mode;
      logic [6:0] zone_floor;
      logic [6:0] zone_ceiling;
   } cfg_type;

   typedef struct packed {
      logic [7:0]        status;
      logic [6:0]        note;
      logic [6:0]        vel;
      logic [15:0]       pos;
      logic              chord;
      logic signed [8:0] base;
      logic signed [3:0] deg;
      logic              minor;
   } desc_type;

   function automatic logic [3:0] mod12(input logic [6:0] n);
      logic [12:0] prod;
      logic [3:0]  q;
      logic [7:0]  q12;
      logic [7:0]  r;
      prod = {6'd0, n} * 13'd43;
      q    = prod[12:9];
      q12  = {4'd0, q} * 8'd12;
      r    = {1'b0, n} - q12;
      return r[3:0];
   endfunction

   function automatic logic [3:0] scale_step(input logic minor, input logic [2:0] idx);
      logic [3:0] s;
      case (idx)
         3'd0: s = 4'd0;
         3'd1: s = 4'd2;
         3'd2: s = minor ? 4'd3 : 4'd4;
         3'd3: s = 4'd5;
         3'd4: s = 4'd7;
         3'd5: s = minor ? 4'd8 : 4'd9;
         3'd6: s = minor ? 4'd10 : 4'd11;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   function automatic logic signed [3:0] degree_of(input logic minor, input logic [3:0] rel);
      logic signed [3:0] d;
      d = NO_DEGREE;
      for (int i = 0; i < 7; i++) begin
         if (scale_step(minor, 3'(i)) == rel) d = 4'(i);
      end
      return d;
   endfunction

   function automatic logic [3:0] chord_offset(input logic [1:0] k);
      logic [3:0] o;
      case (k)
         2'd0: o = 4'd0;
         2'd1: o = 4'd4;
         2'd2: o = 4'd7;
         2'd3: o = 4'd9;
         default: o = 4'd0;
      endcase
      return o;
   endfunction

endpackage

>>> rtl/core/dch_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dch_front
// Classifies each request, tracks held keys and queues a descriptor for it.
// ---------------------------------------------------------------------------
module dch_front (
   input  logic              clock,
   input  logic              reset,
   input  dch_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_status_byte,
   input  logic [6:0]        req_data_one,
   input  logic [6:0]        req_data_two,
   input  logic [15:0]       req_sample_pos,
   input  logic              queue_full,
   output logic              push,
   output dch_pkg::desc_type desc
);
   import dch_pkg::*;

   logic [127:0]      held_ff;
   logic [127:0]      held_in;
   logic [3:0]        kind;
   logic              vel_zero;
   logic              is_on;
   logic              is_off;
   logic [3:0]        root_mod;
   logic [3:0]        note_mod;
   logic [3:0]        rel;
   logic signed [3:0] deg;
   logic              in_zone;
   logic              fire;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      kind     = req_status_byte[7:4];
      vel_zero = (req_data_two == 7'd0);
      is_on    = (kind == KIND_NOTE_ON) && !vel_zero;
      is_off   = (kind == KIND_NOTE_OFF) || ((kind == KIND_NOTE_ON) && vel_zero);
      root_mod = (cfg.root_key >= PITCH_CLASSES) ? cfg.root_key - PITCH_CLASSES
                                                 : cfg.root_key;
      note_mod = mod12(req_data_one);
      if (note_mod >= root_mod) begin
         rel = note_mod - root_mod;
      end else begin
         rel = (PITCH_CLASSES - root_mod) + note_mod;
      end
      deg     = degree_of(cfg.minor_mode, rel);
      in_zone = (req_data_one >= cfg.zone_floor) && (req_data_one <= cfg.zone_ceiling);
      fire    = is_on ? ((deg != NO_DEGREE) && in_zone)
                      : (is_off && held_ff[req_data_one]);

      desc.note  = req_data_one;
      desc.vel   = req_data_two;
      desc.pos   = req_sample_pos;
      desc.chord = fire;
      desc.base  = $signed({2'b00, req_data_one}) - $signed({5'd0, rel});
      desc.deg   = deg;
      desc.minor = cfg.minor_mode;
      if (fire) begin
         desc.status = {(is_on ? KIND_NOTE_ON : KIND_NOTE_OFF), req_status_byte[3:0]};
      end else begin
         desc.status = req_status_byte;
      end

      held_in = held_ff;
      if (push && fire) begin
         held_in[req_data_one] = is_on;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule

>>> rtl/core/dch_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dch_queue
// Short descriptor queue between the front and the back.
// ---------------------------------------------------------------------------
module dch_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dch_pkg::desc_type push_desc,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output dch_pkg::desc_type head_desc
);
   import dch_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   desc_type      slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff;
   logic [AW-1:0] wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff;
   logic [AW-1:0] rd_ptr_in;
   logic [AW:0]   count_ff;
   logic [AW:0]   count_in;

   assign full       = (count_ff == (AW+1)'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/core/dch_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dch_back
// Expands queued descriptors into one pass-through or four chord responses.
// ---------------------------------------------------------------------------
module dch_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  dch_pkg::desc_type head_desc,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_status,
   output logic [6:0]        rsp_out_data_one,
   output logic [6:0]        rsp_out_data_two,
   output logic [15:0]       rsp_out_sample_pos,
   output logic              rsp_last_of_run
);
   import dch_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [1:0]        k_ff;
   logic [1:0]        k_in;
   logic [7:0]        status_ff;
   logic [6:0]        data_one_ff;
   logic [6:0]        data_two_ff;
   logic [15:0]       pos_ff;
   logic              last_ff;
   logic              load;
   logic              last;
   logic signed [4:0] d;
   logic [2:0]        idx;
   logic signed [9:0] oct12;
   logic signed [9:0] raw;
   logic [6:0]        pitch;

   always_comb begin
      d = $signed({head_desc.deg[3], head_desc.deg})
        + $signed({1'b0, chord_offset(k_ff)});
      if (d < 0) begin
         idx   = 3'd6;
         oct12 = -10'sd12;
      end else if (d >= 5'sd14) begin
         idx   = 3'(d - 5'sd14);
         oct12 = 10'sd24;
      end else if (d >= 5'sd7) begin
         idx   = 3'(d - 5'sd7);
         oct12 = 10'sd12;
      end else begin
         idx   = d[2:0];
         oct12 = 10'sd0;
      end
      raw = 10'(head_desc.base) + oct12
          + $signed({6'd0, scale_step(head_desc.minor, idx)});
      if (raw < 0) begin
         pitch = 7'd0;
      end else if (raw > 10'sd127) begin
         pitch = 7'd127;
      end else begin
         pitch = raw[6:0];
      end

      load     = head_valid && (!valid_ff || rsp_ready);
      last     = !head_desc.chord || (k_ff == 2'd3);
      pop      = load && last;
      valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);
      k_in     = k_ff;
      if (load) begin
         k_in = last ? 2'd0 : k_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         k_ff     <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff   <= head_desc.status;
         data_one_ff <= head_desc.chord ? pitch : head_desc.note;
         data_two_ff <= head_desc.vel;
         pos_ff      <= head_desc.pos;
         last_ff     <= last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_status     = status_ff;
   assign rsp_out_data_one   = data_one_ff;
   assign rsp_out_data_two   = data_two_ff;
   assign rsp_out_sample_pos = pos_ff;
   assign rsp_last_of_run    = last_ff;

endmodule

>>> rtl/core/diatonic_chord_harmonizer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// diatonic_chord_harmonizer
// Turns in-scale, in-zone note events into four-note diatonic chords.
// Each accepted request is queued, then loaded into the output register.
// Throughput: one request per cycle in while the queue has room; the back end
// sends one response for a pass-through request and four for a chord request,
// one response per cycle from its output register while rsp_ready is high.
// Reset: synchronous; clears held keys, queue and output valid, loads defaults.
// ---------------------------------------------------------------------------
module diatonic_chord_harmonizer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_status_byte,
   input  logic [6:0]  req_data_one,
   input  logic [6:0]  req_data_two,
   input  logic [15:0] req_sample_pos,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_status,
   output logic [6:0]  rsp_out_data_one,
   output logic [6:0]  rsp_out_data_two,
   output logic [15:0] rsp_out_sample_pos,
   output logic        rsp_last_of_run
);
   import dch_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   desc_type push_desc;
   desc_type head_desc;
   logic     push;
   logic     pop;
   logic     queue_full;
   logic     head_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ROOT_KEY:     cfg_in.root_key     = csr_data[3:0];
            CSR_MINOR_MODE:   cfg_in.minor_mode   = csr_data[0];
            CSR_ZONE_FLOOR:   cfg_in.zone_floor   = csr_data[6:0];
            CSR_ZONE_CEILING: cfg_in.zone_ceiling = csr_data[6:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.root_key     <= 4'd0;
         cfg_ff.minor_mode   <= 1'b0;
         cfg_ff.zone_floor   <= 7'd48;
         cfg_ff.zone_ceiling <= 7'd72;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dch_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_status_byte (req_status_byte),
      .req_data_one    (req_data_one),
      .req_data_two    (req_data_two),
      .req_sample_pos  (req_sample_pos),
      .queue_full      (queue_full),
      .push            (push),
      .desc            (push_desc)
   );

   dch_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   dch_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_desc          (head_desc),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_status     (rsp_out_status),
      .rsp_out_data_one   (rsp_out_data_one),
      .rsp_out_data_two   (rsp_out_data_two),
      .rsp_out_sample_pos (rsp_out_sample_pos),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

>>> rtl/core/dch_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dch_checker
// Port-level checks on the harmonizer's response stream.
// ---------------------------------------------------------------------------
module dch_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_status,
   input logic [15:0] rsp_out_sample_pos,
   input logic        rsp_last_of_run
);

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_sample_pos)
                                     && $stable(rsp_out_status)))
      else $error("stalled response changed");

   a_run_is_note: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> (rsp_out_status[7:5] == 3'b100))
      else $error("multi-response run without note status");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run)
         |=> (rsp_valid && (rsp_out_sample_pos == $past(rsp_out_sample_pos))))
      else $error("chord run broken");

endmodule

bind diatonic_chord_harmonizer dch_checker u_dch_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_out_status     (rsp_out_status),
   .rsp_out_sample_pos (rsp_out_sample_pos),
   .rsp_last_of_run    (rsp_last_of_run)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the diatonic chord harmonizer. A scoreboard model
// turns every accepted MIDI request into its expected responses (pass-through
// or four-note chord on/off) while directed and random tests drive the request
// and register channels with random idling and one long response hold-off.
// ---------------------------------------------------------------------------
module testbench;
   import dch_pkg::*;

   localparam int          RUN_LIMIT        = 200000;
   localparam int          HOLD_OFF_CYCLES  = 300;
   localparam int          DRAIN_CYCLES     = 8;
   localparam logic [3:0]  KIND_POLY_PRESS  = 4'hA;
   localparam logic [3:0]  KIND_CONTROL     = 4'hB;
   localparam logic [3:0]  KIND_SYSTEM      = 4'hF;
   localparam logic [27:0] MAJOR_STEPS      = {4'd11, 4'd9, 4'd7, 4'd5, 4'd4, 4'd2, 4'd0};
   localparam logic [27:0] MINOR_STEPS      = {4'd10, 4'd8, 4'd7, 4'd5, 4'd3, 4'd2, 4'd0};
   localparam logic [15:0] CHORD_SPAN       = {4'd9, 4'd7, 4'd4, 4'd0};

   typedef struct packed {
      logic [7:0]  status;
      logic [6:0]  data_one;
      logic [6:0]  data_two;
      logic [15:0] sample_pos;
      logic        last;
   } midi_event_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [7:0]    csr_data;
   logic          req_valid;
   logic          req_ready;
   logic [7:0]    req_status_byte;
   logic [6:0]    req_data_one;
   logic [6:0]    req_data_two;
   logic [15:0]   req_sample_pos;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [7:0]    rsp_out_status;
   logic [6:0]    rsp_out_data_one;
   logic [6:0]    rsp_out_data_two;
   logic [15:0]   rsp_out_sample_pos;
   logic          rsp_last_of_run;

   logic           idling_on = 1'b1;
   logic           hold_off_active = 1'b0;
   event           hold_off_start;
   cfg_type        harmony_cfg;
   logic [127:0]   held_keys_model;
   midi_event_type expected_events[$];
   int             requests_sent = 0;
   int             chords_struck = 0;
   int             chords_released = 0;
   int             settings_applied = 1;
   int             responses_checked = 0;
   int             mismatch_count = 0;
   int unsigned    cycle_count = 0;

   diatonic_chord_harmonizer i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, expected_events.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------ model
   function automatic int scale_step(input logic minor, input int idx);
      return minor ? int'(MINOR_STEPS[4*idx +: 4]) : int'(MAJOR_STEPS[4*idx +: 4]);
   endfunction

   function automatic int scale_degree(input logic minor, input int rel);
      int degree;
      degree = -1;
      for (int i = 0; i < 7; i++)
         if (scale_step(minor, i) == rel) degree = i;
      return degree;
   endfunction

   function automatic int chord_pitch(input int base, input logic minor, input int degree);
      int octave;
      int idx;
      int pitch;
      octave = 0;
      idx = degree;
      while (idx < 0) begin
         idx += 7;
         octave--;
      end
      octave += idx / 7;
      idx = idx % 7;
      pitch = base + octave * 12 + scale_step(minor, idx);
      if (pitch < 0) pitch = 0;
      if (pitch > 127) pitch = 127;
      return pitch;
   endfunction

   function automatic int relative_class(input logic [6:0] note);
      return (int'(note) % 12 - int'(harmony_cfg.root_key) % 12 + 12) % 12;
   endfunction

   task automatic harmonize_request(input logic [7:0] status, input logic [6:0] note,
                                    input logic [6:0] velocity, input logic [15:0] position);
      logic [3:0]     kind;
      logic           note_on;
      logic           note_off;
      logic           strike;
      int             rel;
      int             degree;
      midi_event_type ev;
      kind = status[7:4];
      note_on = (kind == KIND_NOTE_ON) && (velocity != 7'd0);
      note_off = (kind == KIND_NOTE_OFF) || ((kind == KIND_NOTE_ON) && (velocity == 7'd0));
      strike = 1'b0;
      rel = relative_class(note);
      degree = scale_degree(harmony_cfg.minor_mode, rel);
      if (note_on) begin
         if (degree >= 0 && note >= harmony_cfg.zone_floor
             && note <= harmony_cfg.zone_ceiling) begin
            held_keys_model[note] = 1'b1;
            strike = 1'b1;
            chords_struck++;
         end
      end else if (note_off && held_keys_model[note]) begin
         held_keys_model[note] = 1'b0;
         strike = 1'b1;
         chords_released++;
      end
      if (strike) begin
         for (int k = 0; k < 4; k++) begin
            ev.status = {note_on ? KIND_NOTE_ON : KIND_NOTE_OFF, status[3:0]};
            ev.data_one = 7'(chord_pitch(int'(note) - rel, harmony_cfg.minor_mode,
                                         degree + int'(CHORD_SPAN[4*k +: 4])));
            ev.data_two = velocity;
            ev.sample_pos = position;
            ev.last = (k == 3);
            expected_events.push_back(ev);
         end
      end else begin
         expected_events.push_back('{status, note, velocity, position, 1'b1});
      end
   endtask

   // ---------------------------------------------------------------- drivers
   task automatic send_request(input logic [7:0] status, input logic [6:0] note,
                               input logic [6:0] velocity, input logic [15:0] position);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_status_byte <= status;
      req_data_one <= note;
      req_data_two <= velocity;
      req_sample_pos <= position;
      do @(posedge clock); while (req_ready !== 1'b1);
      harmonize_request(status, note, velocity, position);
      requests_sent++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_ROOT_KEY:     harmony_cfg.root_key = value[3:0];
         CSR_MINOR_MODE:   harmony_cfg.minor_mode = value[0];
         CSR_ZONE_FLOOR:   harmony_cfg.zone_floor = value[6:0];
         CSR_ZONE_CEILING: harmony_cfg.zone_ceiling = value[6:0];
         default: ;
      endcase
   endtask

   // write every register; unused upper data bits carry noise
   task automatic configure(input logic [3:0] root, input logic minor,
                            input logic [6:0] low, input logic [6:0] high);
      write_csr(CSR_ROOT_KEY, {4'($urandom), root});
      write_csr(CSR_MINOR_MODE, {7'($urandom), minor});
      write_csr(CSR_ZONE_FLOOR, {1'($urandom), low});
      write_csr(CSR_ZONE_CEILING, {1'($urandom), high});
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------- response side
   always @(posedge clock) begin : drive_rsp_ready
      int stall_left;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (hold_off_active) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 13);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial forever begin
      @(hold_off_start);
      hold_off_active <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off_active <= 1'b0;
   end

   always @(posedge clock) begin : check_responses
      midi_event_type got;
      midi_event_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got = '{rsp_out_status, rsp_out_data_one, rsp_out_data_two,
                 rsp_out_sample_pos, rsp_last_of_run};
         responses_checked++;
         if (expected_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected response: status %h note %0d vel %0d pos %h last %b",
                        got.status, got.data_one, got.data_two, got.sample_pos, got.last);
         end else begin
            want = expected_events.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"Mismatch: expected status %h note %0d vel %0d pos %h last %b,",
                            " got status %h note %0d vel %0d pos %h last %b"},
                           want.status, want.data_one, want.data_two, want.sample_pos,
                           want.last, got.status, got.data_one, got.data_two,
                           got.sample_pos, got.last);
            end
         end
      end
   end

   // ------------------------------------------------------------------ tests
   task automatic test_pass_through();
      send_request(8'h00, 7'd0, 7'd0, 16'h0000);
      send_request(8'h7F, 7'd127, 7'd127, 16'hFFFF);
      send_request({KIND_POLY_PRESS, 4'd3}, 7'd60, 7'd100, 16'h1234);
      send_request({KIND_CONTROL, 4'd0}, 7'd7, 7'd127, 16'h8001);
      send_request({KIND_SYSTEM, 4'hF}, 7'd0, 7'd127, 16'h00FF);
      send_request({KIND_NOTE_OFF, 4'hF}, 7'd60, 7'd64, 16'h5A5A);
      send_request({KIND_NOTE_ON, 4'd5}, 7'd62, 7'd0, 16'hA5A5);
   endtask

   // reset settings: C major, zone 48..72
   task automatic test_default_chords();
      send_request({KIND_NOTE_ON, 4'd0}, 7'd60, 7'd127, 16'h0000);
      send_request({KIND_NOTE_ON, 4'd0}, 7'd61, 7'd90, 16'h0010);
      send_request({KIND_NOTE_ON, 4'd0}, 7'd47, 7'd90, 16'h0020);
      send_request({KIND_NOTE_ON, 4'd0}, 7'd73, 7'd90, 16'h0030);
      send_request({KIND_NOTE_ON, 4'hF}, 7'd48, 7'd1, 16'h0040);
      send_request({KIND_NOTE_ON, 4'hF}, 7'd72, 7'd80, 16'h0050);
      send_request({KIND_NOTE_ON, 4'd0}, 7'd60, 7'd33, 16'h0060);
      send_request({KIND_NOTE_OFF, 4'd0}, 7'd60, 7'd12, 16'h0070);
      send_request({KIND_NOTE_ON, 4'hF}, 7'd48, 7'd0, 16'h0080);
      send_request({KIND_NOTE_OFF, 4'hF}, 7'd72, 7'd127, 16'hFFFF);
      send_request({KIND_NOTE_OFF, 4'hF}, 7'd72, 7'd127, 16'hFFFE);
   endtask

   // out-of-range root, full zone, empty zone and release of off-scale keys
   task automatic test_register_extremes();
      wait_for_drain();
      configure(4'd15, 1'b1, 7'd0, 7'd127);
      send_request({KIND_NOTE_ON, 4'd1}, 7'd0, 7'd100, 16'h0100);
      send_request({KIND_NOTE_ON, 4'd1}, 7'd3, 7'd100, 16'h0200);
      send_request({KIND_NOTE_ON, 4'd1}, 7'd125, 7'd127, 16'h0300);
      send_request({KIND_NOTE_ON, 4'd1}, 7'd127, 7'd127, 16'h0400);
      wait_for_drain();
      configure(4'd0, 1'b0, 7'd0, 7'd127);
      send_request({KIND_NOTE_ON, 4'd2}, 7'd0, 7'd1, 16'h0500);
      send_request({KIND_NOTE_ON, 4'd2}, 7'd127, 7'd127, 16'h0600);
      wait_for_drain();
      configure(4'd2, 1'b0, 7'd100, 7'd20);
      send_request({KIND_NOTE_ON, 4'd4}, 7'd60, 7'd70, 16'h0700);
      send_request({KIND_NOTE_OFF, 4'd4}, 7'd0, 7'd70, 16'h0800);
      send_request({KIND_NOTE_OFF, 4'd4}, 7'd127, 7'd0, 16'h0900);
      send_request({KIND_NOTE_ON, 4'd4}, 7'd3, 7'd0, 16'h0A00);
      send_request({KIND_NOTE_OFF, 4'd4}, 7'd125, 7'd55, 16'h0B00);
   endtask

   // hold the response side off so the block fills and stalls its input
   task automatic test_backpressure();
      logic [6:0] note;
      wait_for_drain();
      configure(4'd7, 1'b0, 7'd24, 7'd100);
      -> hold_off_start;
      repeat (16) begin
         do note = 7'($urandom_range(24, 100));
         while (scale_degree(harmony_cfg.minor_mode, relative_class(note)) < 0);
         send_request({KIND_NOTE_ON, 4'($urandom)}, note, 7'($urandom_range(1, 127)),
                      16'($urandom));
      end
   endtask

   task automatic send_random_request();
      int         pick;
      int         skip;
      logic [6:0] note;
      logic [3:0] chan;
      logic [15:0] position;
      pick = $urandom_range(0, 99);
      chan = 4'($urandom);
      position = 16'($urandom);
      note = 7'($urandom);
      if (pick < 45) begin
         if (harmony_cfg.zone_floor <= harmony_cfg.zone_ceiling)
            note = 7'($urandom_range(harmony_cfg.zone_floor, harmony_cfg.zone_ceiling));
         send_request({KIND_NOTE_ON, chan}, note, 7'($urandom_range(1, 127)), position);
      end else if (pick < 75 && held_keys_model != '0) begin
         skip = $urandom_range(0, $countones(held_keys_model) - 1);
         for (int n = 0; n < 128; n++) begin
            if (held_keys_model[n]) begin
               if (skip == 0) note = 7'(n);
               skip--;
            end
         end
         if ($urandom_range(0, 1))
            send_request({KIND_NOTE_OFF, chan}, note, 7'($urandom), position);
         else
            send_request({KIND_NOTE_ON, chan}, note, 7'd0, position);
      end else if (pick < 85) begin
         send_request({$urandom_range(0, 1) ? KIND_NOTE_ON : KIND_NOTE_OFF, chan}, note,
                      7'($urandom), position);
      end else begin
         send_request(8'($urandom), note, 7'($urandom), position);
      end
   endtask

   task automatic test_random_traffic();
      logic [6:0] low;
      logic [6:0] high;
      for (int phase = 0; phase < 4; phase++) begin
         wait_for_drain();
         low = 7'($urandom_range(0, 64));
         high = 7'($urandom_range(56, 127));
         if (phase == 1) begin
            low = 7'd0;
            high = 7'd127;
         end else if (phase == 2 && $urandom_range(0, 1)) begin
            low = 7'($urandom_range(80, 127));
            high = 7'($urandom_range(0, 79));
         end else if (phase == 3) begin
            idling_on <= 1'b0;
         end
         configure(4'($urandom), 1'($urandom), low, high);
         repeat (22) send_random_request();
      end
   endtask

   initial begin
      harmony_cfg = '{root_key: 4'd0, minor_mode: 1'b0, zone_floor: 7'd48,
                      zone_ceiling: 7'd72};
      held_keys_model = '0;
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= CSR_ROOT_KEY;
      csr_data <= 8'd0;
      req_valid <= 1'b0;
      req_status_byte <= 8'd0;
      req_data_one <= 7'd0;
      req_data_two <= 7'd0;
      req_sample_pos <= 16'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_pass_through();
      test_default_chords();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      wait_for_drain();

      $display("Covered %0d requests: %0d chords struck, %0d released, %0d register settings",
               requests_sent, chords_struck, chords_released, settings_applied);
      $display("Checked %0d responses with %0d mismatches", responses_checked, mismatch_count);
      if (mismatch_count == 0 && expected_events.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/core/dch_pkg.sv
rtl/core/dch_front.sv
rtl/core/dch_queue.sv
rtl/core/dch_back.sv
rtl/core/diatonic_chord_harmonizer.sv
rtl/core/dch_checker.sv
test/testbench.sv
